>>> hw/rtl/irlt_pkg.sv
`timescale 1ns / 1ps

package irlt_pkg;

  localparam int DEF_ROUTE_ENTRIES = 16;
  localparam int DEF_PORT_COUNT    = 4;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 16;
  localparam int IDX_W      = 4;
  localparam int ADDR_W     = 32;
  localparam int PORT_W     = 2;
  localparam int TTL_W      = 8;
  localparam int LEN_W      = 6;

  // operation codes on the input tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // action codes on the output tuser
  localparam logic [1:0] ACT_FORWARD      = 2'd0;
  localparam logic [1:0] ACT_TTL_EXCEEDED = 2'd1;
  localparam logic [1:0] ACT_NO_ROUTE     = 2'd2;
  localparam logic [1:0] ACT_WRITE_DONE   = 2'd3;

  // command kinds passed from front to back
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_EXPIRED = 2'd1;
  localparam logic [1:0] CMD_LOOKUP  = 2'd2;

  localparam int CMD_FIFO_DEPTH = 2;
  localparam int CMD_FIFO_PTR_W = $clog2(CMD_FIFO_DEPTH);

  typedef struct packed {
    logic [1:0]        kind;
    logic              wr_en;     // write lands in the table
    logic [IDX_W-1:0]  index;
    logic              valid;
    logic [ADDR_W-1:0] addr;      // route prefix for writes, destination for lookups
    logic [ADDR_W-1:0] mask;
    logic [LEN_W-1:0]  mask_len;
    logic [PORT_W-1:0] port;
    logic [TTL_W-1:0]  ttl;       // decremented ttl for lookups
  } cmd_t;

endpackage

>>> hw/rtl/irlt_front.sv
`timescale 1ns / 1ps

module irlt_front #(
  parameter int ROUTE_ENTRIES = irlt_pkg::DEF_ROUTE_ENTRIES,
  parameter int PORT_COUNT    = irlt_pkg::DEF_PORT_COUNT
) (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [irlt_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  input  logic                           q_full,
  output logic                           push,
  output irlt_pkg::cmd_t                 cmd
);

  localparam logic [8:0] ENTRY_LIM = 9'(ROUTE_ENTRIES);
  localparam logic [4:0] PORT_LIM  = 5'(PORT_COUNT);

  logic [irlt_pkg::IDX_W-1:0]  entry_index;
  logic                        entry_valid;
  logic [irlt_pkg::ADDR_W-1:0] route_prefix;
  logic [irlt_pkg::ADDR_W-1:0] route_mask;
  logic [irlt_pkg::PORT_W-1:0] route_port;
  logic [irlt_pkg::ADDR_W-1:0] dst_ip;
  logic [irlt_pkg::TTL_W-1:0]  ttl_in;

  assign entry_index  = s_tdata[3:0];
  assign entry_valid  = s_tdata[4];
  assign route_prefix = s_tdata[36:5];
  assign route_mask   = s_tdata[68:37];
  assign route_port   = s_tdata[70:69];
  assign dst_ip       = s_tdata[102:71];
  assign ttl_in       = s_tdata[110:103];

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    cmd          = '0;
    cmd.index    = entry_index;
    cmd.valid    = entry_valid;
    cmd.mask     = route_mask;
    cmd.port     = route_port;
    cmd.mask_len = irlt_pkg::LEN_W'($countones(route_mask));
    cmd.wr_en    = (9'(entry_index) < ENTRY_LIM) && (5'(route_port) < PORT_LIM);
    if (s_tuser == irlt_pkg::OP_WRITE) begin
      cmd.kind = irlt_pkg::CMD_WRITE;
      cmd.addr = route_prefix;
    end else begin
      cmd.addr  = dst_ip;
      cmd.wr_en = 1'b0;
      // ttl of 0 or 1 expires here and never reaches the table
      if (ttl_in <= 8'd1) begin
        cmd.kind = irlt_pkg::CMD_EXPIRED;
      end else begin
        cmd.kind = irlt_pkg::CMD_LOOKUP;
        cmd.ttl  = ttl_in - 8'd1;
      end
    end
  end

endmodule

>>> hw/rtl/irlt_cmd_queue.sv
`timescale 1ns / 1ps

module irlt_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  irlt_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output irlt_pkg::cmd_t head
);

  localparam int PW = irlt_pkg::CMD_FIFO_PTR_W;
  localparam int CW = PW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(irlt_pkg::CMD_FIFO_DEPTH);

  irlt_pkg::cmd_t slots [irlt_pkg::CMD_FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == DEPTH_C);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

endmodule

>>> hw/rtl/irlt_back.sv
`timescale 1ns / 1ps

module irlt_back #(
  parameter int ROUTE_ENTRIES = irlt_pkg::DEF_ROUTE_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  irlt_pkg::cmd_t                  q_cmd,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [irlt_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]                      m_tuser
);

  localparam int TW    = $clog2(ROUTE_ENTRIES);
  localparam int EXT_W = (TW > irlt_pkg::IDX_W) ? TW : irlt_pkg::IDX_W;
  localparam logic [TW:0] CNT_N = (TW + 1)'(ROUTE_ENTRIES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic [irlt_pkg::ADDR_W-1:0] mem_prefix [ROUTE_ENTRIES];
  logic [irlt_pkg::ADDR_W-1:0] mem_mask   [ROUTE_ENTRIES];
  logic [irlt_pkg::LEN_W-1:0]  mem_len    [ROUTE_ENTRIES];
  logic [irlt_pkg::PORT_W-1:0] mem_port   [ROUTE_ENTRIES];
  logic [ROUTE_ENTRIES-1:0]    slot_valid;

  logic        state;
  logic [TW:0] cnt;
  logic [TW-1:0] rd_addr;
  logic [TW-1:0] wr_addr;
  logic [EXT_W-1:0] wr_ext;
  logic [EXT_W-1:0] hit_ext;

  logic                        rd_live;
  logic [TW-1:0]               rd_idx;
  logic                        rd_valid;
  logic [irlt_pkg::ADDR_W-1:0] rd_prefix;
  logic [irlt_pkg::ADDR_W-1:0] rd_mask;
  logic [irlt_pkg::LEN_W-1:0]  rd_len;
  logic [irlt_pkg::PORT_W-1:0] rd_port;

  logic [irlt_pkg::ADDR_W-1:0] cur_dest;
  logic [irlt_pkg::TTL_W-1:0]  cur_ttl;

  logic                        found;
  logic [irlt_pkg::LEN_W-1:0]  best_len;
  logic [TW-1:0]               best_idx;
  logic [irlt_pkg::PORT_W-1:0] best_port;

  logic hit;
  logic scan_done;
  logic out_free;
  logic out_load;
  logic is_write;
  logic is_lookup;

  logic                        out_valid;
  logic [1:0]                  out_action;
  logic [irlt_pkg::PORT_W-1:0] out_port;
  logic [irlt_pkg::IDX_W-1:0]  out_hit;
  logic [irlt_pkg::TTL_W-1:0]  out_ttl;
  logic [1:0]                  out_action_next;
  logic [irlt_pkg::PORT_W-1:0] out_port_next;
  logic [irlt_pkg::IDX_W-1:0]  out_hit_next;
  logic [irlt_pkg::TTL_W-1:0]  out_ttl_next;

  assign rd_addr  = cnt[TW-1:0];
  assign wr_ext   = EXT_W'(q_cmd.index);
  assign wr_addr  = wr_ext[TW-1:0];
  assign hit_ext  = EXT_W'(best_idx);

  assign out_free  = !out_valid || m_tready;
  assign pop       = q_valid && (state == ST_IDLE) && out_free;
  assign is_write  = (q_cmd.kind == irlt_pkg::CMD_WRITE);
  assign is_lookup = (q_cmd.kind == irlt_pkg::CMD_LOOKUP);
  assign scan_done = (state == ST_SCAN) && (cnt == CNT_N) && !rd_live;
  assign out_load  = (pop && !is_lookup) || (scan_done && out_free);

  // ties keep the earlier slot since only a strictly longer mask replaces it
  assign hit = rd_live && rd_valid && (((rd_prefix ^ cur_dest) & rd_mask) == '0)
               && (!found || (rd_len > best_len));

  always_comb begin
    out_action_next = irlt_pkg::ACT_WRITE_DONE;
    out_port_next   = '0;
    out_hit_next    = '0;
    out_ttl_next    = '0;
    if (state == ST_SCAN) begin
      out_ttl_next = cur_ttl;
      if (found) begin
        out_action_next = irlt_pkg::ACT_FORWARD;
        out_port_next   = best_port;
        out_hit_next    = hit_ext[irlt_pkg::IDX_W-1:0];
      end else begin
        out_action_next = irlt_pkg::ACT_NO_ROUTE;
      end
    end else if (q_cmd.kind == irlt_pkg::CMD_EXPIRED) begin
      out_action_next = irlt_pkg::ACT_TTL_EXCEEDED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      rd_live    <= 1'b0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
      slot_valid <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop && is_lookup) begin
            state <= ST_SCAN;
            cnt   <= '0;
            found <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (scan_done && out_free) state <= ST_IDLE;
          if (cnt != CNT_N) cnt <= cnt + 1'b1;
          rd_live <= (cnt != CNT_N);
          if (hit) found <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
      if (pop && is_write && q_cmd.wr_en) slot_valid[wr_addr] <= q_cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_write && q_cmd.wr_en) begin
      mem_prefix[wr_addr] <= q_cmd.addr;
      mem_mask[wr_addr]   <= q_cmd.mask;
      mem_len[wr_addr]    <= q_cmd.mask_len;
      mem_port[wr_addr]   <= q_cmd.port;
    end
    rd_prefix <= mem_prefix[rd_addr];
    rd_mask   <= mem_mask[rd_addr];
    rd_len    <= mem_len[rd_addr];
    rd_port   <= mem_port[rd_addr];
    rd_valid  <= slot_valid[rd_addr];
    rd_idx    <= rd_addr;
    if (pop && is_lookup) begin
      cur_dest <= q_cmd.addr;
      cur_ttl  <= q_cmd.ttl;
    end
    if (hit) begin
      best_len  <= rd_len;
      best_idx  <= rd_idx;
      best_port <= rd_port;
    end
    if (out_load) begin
      out_action <= out_action_next;
      out_port   <= out_port_next;
      out_hit    <= out_hit_next;
      out_ttl    <= out_ttl_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_action;
  assign m_tdata  = {2'b00, out_ttl, out_hit, out_port};

`ifndef NO_ASSERTIONS
  a_live_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_live |-> (state == ST_SCAN))
    else $error("table read in flight outside a scan");

  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    (pop && is_lookup) |=> ((state == ST_SCAN) && (cnt == '0) && !found && !rd_live))
    else $error("scan did not start clean");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cnt <= CNT_N))
    else $error("scan counter ran past the table");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (scan_done && out_free) |=> (m_tvalid && (state == ST_IDLE)))
    else $error("finished lookup gave no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !out_load)
    else $error("result register loaded while a beat is pending");
`endif

endmodule

>>> hw/rtl/ipv4_route_lookup_ttl.sv
`timescale 1ns / 1ps

// IPv4 longest-prefix route lookup with ttl check. Input beats carry either a
// route write (tuser 0) or a lookup (tuser 1); every beat gives exactly one
// result beat, in order. Writes and expired-ttl lookups go straight to the
// result register once they reach the back end. A lookup that goes to the
// table holds the back end until its scan ends, so a following command waits
// in the queue: the table sits in a memory with one read port, scanned one
// slot per cycle behind a registered read, and the best match then goes into
// the result register once it is free. A two-entry command queue between the
// decode front and the table back end lets the input keep accepting, until
// the queue is full, while a scan runs or a result waits.
// The valid marks clear at reset; no clearing pass is needed.
module ipv4_route_lookup_ttl #(
  parameter int ROUTE_ENTRIES = irlt_pkg::DEF_ROUTE_ENTRIES,
  parameter int PORT_COUNT    = irlt_pkg::DEF_PORT_COUNT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // entry_index, entry_valid, route_prefix, route_mask, route_port, dst_ip, ttl_in
  input  logic [irlt_pkg::IN_DATA_W-1:0]  s_tdata,
  // operation
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_port, hit_index, ttl_out
  output logic [irlt_pkg::OUT_DATA_W-1:0] m_tdata,
  // action
  output logic [1:0]                      m_tuser
);

  irlt_pkg::cmd_t push_cmd;
  irlt_pkg::cmd_t head_cmd;
  logic push;
  logic q_full;
  logic q_valid;
  logic pop;

  irlt_front #(
    .ROUTE_ENTRIES (ROUTE_ENTRIES),
    .PORT_COUNT    (PORT_COUNT)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  irlt_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head       (head_cmd)
  );

  irlt_back #(
    .ROUTE_ENTRIES (ROUTE_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (head_cmd),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
